// ===== rtl/weekday_alarm_table_defines.svh =====
// Assertion macros shared by the weekday alarm table checker.
// Depends on nothing; the using module provides clk and rst_n.
`ifndef WEEKDAY_ALARM_TABLE_DEFINES_SVH
`define WEEKDAY_ALARM_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WAT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WAT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wat_pkg.sv =====
// Shared types, codes and helpers for the weekday alarm table.
// Used by the controller, the datapath, the top level and the checker.
package wat_pkg;

    localparam int ALARM_SLOTS_DEF = 16;

    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_UPSERT  = 3'd1;
    localparam logic [2:0] MODE_DELETE  = 3'd2;
    localparam logic [2:0] MODE_CLEAR   = 3'd3;
    localparam logic [2:0] MODE_DISMISS = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_ID    = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_IDLE      = 3'd4;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] alarm_id;
        logic [4:0]  alarm_hour;
        logic [5:0]  alarm_minute;
        logic [6:0]  day_mask;
        logic        enable;
        logic [4:0]  now_hour;
        logic [5:0]  now_minute;
        logic [5:0]  now_second;
        logic [2:0]  now_weekday;
        logic [15:0] now_day_number;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        fired_now;
        logic        ringing;
        logic [31:0] ringing_id;
        logic [4:0]  entry_count;
    } out_item_t;

    typedef struct packed {
        logic [31:0] key;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [6:0]  days;
        logic        active;
        logic        fired_valid;
        logic [15:0] fired_day;
    } slot_rec_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic needs_scan;
        logic can_commit;
    } dp_stat_t;

    // An empty mask matches every day; otherwise the weekday must be one to seven.
    function automatic logic day_match(input logic [6:0] mask, input logic [2:0] weekday);
        logic hit;
        hit = 1'b0;
        if (mask == 7'd0)
        begin
            hit = 1'b1;
        end
        else if (weekday != 3'd0)
        begin
            hit = mask[weekday - 3'd1];
        end
        return hit;
    endfunction

endpackage

// ===== rtl/wat_ctrl.sv =====
// Sequencing state machine for the weekday alarm table.
// Depends on wat_pkg; drives the datapath through dp_cmd_t and the scan index.
module wat_ctrl #(
    parameter int ALARM_SLOTS = wat_pkg::ALARM_SLOTS_DEF,
    parameter int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  wat_pkg::dp_stat_t stat,
    output wat_pkg::dp_cmd_t  cmd,
    output logic [IDX_W-1:0]  scan_idx
);

    typedef enum logic [2:0] {
        IDLE,
        CHECK,
        SCAN,
        LAST,
        COMMIT
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALARM_SLOTS - 1);

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = CHECK;
                end
            end
            CHECK:
            begin
                idx_next   = '0;
                state_next = stat.needs_scan ? SCAN : COMMIT;
            end
            SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = LAST;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            LAST:
            begin
                state_next = COMMIT;
            end
            COMMIT:
            begin
                if (stat.can_commit)
                begin
                    cmd.commit = 1'b1;
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign scan_idx = idx_reg;

endmodule

// ===== rtl/wat_dp.sv =====
// Datapath of the weekday alarm table: slot memory, valid bits, scan compare,
// ring state and the output register. Depends on wat_pkg.
module wat_dp #(
    parameter int ALARM_SLOTS = wat_pkg::ALARM_SLOTS_DEF,
    parameter int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  wat_pkg::dp_cmd_t   cmd,
    input  logic [IDX_W-1:0]   scan_idx,
    input  wat_pkg::in_item_t  in_data,
    input  logic               out_ready,
    output wat_pkg::dp_stat_t  stat,
    output logic               out_valid,
    output wat_pkg::out_item_t out_data
);

    localparam int CNT_W = $clog2(ALARM_SLOTS + 1);

    wat_pkg::slot_rec_t mem [ALARM_SLOTS];
    wat_pkg::slot_rec_t rd_rec_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               rd_live_reg;

    wat_pkg::in_item_t  item_reg;

    logic               found_reg;
    logic [IDX_W-1:0]   found_pos_reg;
    logic               free_reg;
    logic [IDX_W-1:0]   free_pos_reg;
    logic               best_reg;
    logic [IDX_W-1:0]   best_pos_reg;
    wat_pkg::slot_rec_t best_rec_reg;

    logic [ALARM_SLOTS-1:0] valid_reg;
    logic [ALARM_SLOTS-1:0] valid_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   ring_reg;
    logic                   ring_next;
    logic [31:0]            ring_key_reg;
    logic [31:0]            ring_key_next;
    logic                   out_valid_reg;
    wat_pkg::out_item_t     out_reg;

    logic                   slot_vld;
    logic                   key_hit;
    logic                   free_hit;
    logic                   cand;
    logic                   better;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    wat_pkg::slot_rec_t     wr_rec;
    logic [2:0]             st;
    logic                   fired;
    logic [CNT_W+4:0]       cnt_wide;

    assign slot_vld = valid_reg[rd_idx_reg];
    assign key_hit  = rd_live_reg && slot_vld && (rd_rec_reg.key == item_reg.alarm_id);
    assign free_hit = rd_live_reg && !slot_vld;
    assign cand     = rd_live_reg && slot_vld && rd_rec_reg.active
                      && !(rd_rec_reg.fired_valid
                           && (rd_rec_reg.fired_day == item_reg.now_day_number))
                      && ({rd_rec_reg.hour, rd_rec_reg.minute}
                          == {item_reg.now_hour, item_reg.now_minute})
                      && wat_pkg::day_match(rd_rec_reg.days, item_reg.now_weekday);
    assign better   = cand && (!best_reg || (rd_rec_reg.key < best_rec_reg.key));

    assign stat.needs_scan = ((item_reg.mode == wat_pkg::MODE_TICK) && !ring_reg
                              && (item_reg.now_second == 6'd0))
                          || (((item_reg.mode == wat_pkg::MODE_UPSERT)
                               || (item_reg.mode == wat_pkg::MODE_DELETE))
                              && (item_reg.alarm_id != 32'd0));
    assign stat.can_commit = !out_valid_reg || out_ready;

    always_comb
    begin
        wr_en         = 1'b0;
        wr_addr       = best_pos_reg;
        wr_rec        = best_rec_reg;
        valid_next    = valid_reg;
        count_next    = count_reg;
        ring_next     = ring_reg;
        ring_key_next = ring_key_reg;
        st            = wat_pkg::ST_OK;
        fired         = 1'b0;
        case (item_reg.mode)
            wat_pkg::MODE_TICK:
            begin
                if (best_reg)
                begin
                    ring_next          = 1'b1;
                    ring_key_next      = best_rec_reg.key;
                    wr_en              = 1'b1;
                    wr_rec.fired_valid = 1'b1;
                    wr_rec.fired_day   = item_reg.now_day_number;
                    fired              = 1'b1;
                end
            end
            wat_pkg::MODE_UPSERT:
            begin
                if (item_reg.alarm_id == 32'd0)
                begin
                    st = wat_pkg::ST_BAD_ID;
                end
                else if (found_reg || free_reg)
                begin
                    wr_en              = 1'b1;
                    wr_addr            = found_reg ? found_pos_reg : free_pos_reg;
                    wr_rec.key         = item_reg.alarm_id;
                    wr_rec.hour        = item_reg.alarm_hour;
                    wr_rec.minute      = item_reg.alarm_minute;
                    wr_rec.days        = item_reg.day_mask;
                    wr_rec.active      = item_reg.enable;
                    wr_rec.fired_valid = 1'b0;
                    wr_rec.fired_day   = 16'd0;
                    valid_next[wr_addr] = 1'b1;
                    if (!found_reg)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                else
                begin
                    st = wat_pkg::ST_FULL;
                end
            end
            wat_pkg::MODE_DELETE:
            begin
                if (item_reg.alarm_id == 32'd0)
                begin
                    st = wat_pkg::ST_BAD_ID;
                end
                else if (found_reg)
                begin
                    valid_next[found_pos_reg] = 1'b0;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    st = wat_pkg::ST_NOT_FOUND;
                end
            end
            wat_pkg::MODE_CLEAR:
            begin
                valid_next = '0;
                count_next = '0;
            end
            wat_pkg::MODE_DISMISS:
            begin
                if (ring_reg)
                begin
                    ring_next     = 1'b0;
                    ring_key_next = 32'd0;
                end
                else
                begin
                    st = wat_pkg::ST_IDLE;
                end
            end
            default:
            begin
                st = wat_pkg::ST_OK;
            end
        endcase
    end

    assign cnt_wide = (CNT_W + 5)'(count_next);

    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_en)
        begin
            mem[wr_addr] <= wr_rec;
        end
        if (cmd.rd_en)
        begin
            rd_rec_reg <= mem[scan_idx];
            rd_idx_reg <= scan_idx;
        end
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (found_reg == 1'b0 && key_hit)
        begin
            found_pos_reg <= rd_idx_reg;
        end
        if (free_reg == 1'b0 && free_hit)
        begin
            free_pos_reg <= rd_idx_reg;
        end
        if (better)
        begin
            best_pos_reg <= rd_idx_reg;
            best_rec_reg <= rd_rec_reg;
        end
        if (cmd.commit)
        begin
            out_reg.status      <= st;
            out_reg.fired_now   <= fired;
            out_reg.ringing     <= ring_next;
            out_reg.ringing_id  <= ring_key_next;
            out_reg.entry_count <= cnt_wide[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_live_reg   <= 1'b0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            best_reg      <= 1'b0;
            valid_reg     <= '0;
            count_reg     <= '0;
            ring_reg      <= 1'b0;
            ring_key_reg  <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_live_reg <= cmd.rd_en;
            if (cmd.load)
            begin
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
                best_reg  <= 1'b0;
            end
            else
            begin
                if (key_hit)
                begin
                    found_reg <= 1'b1;
                end
                if (free_hit)
                begin
                    free_reg <= 1'b1;
                end
                if (better)
                begin
                    best_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                valid_reg     <= valid_next;
                count_reg     <= count_next;
                ring_reg      <= ring_next;
                ring_key_reg  <= ring_key_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/weekday_alarm_table.sv =====
// Weekday alarm table: one result beat for every input beat, in order. Tick,
// upsert and delete beats with work to do walk every slot through a single
// memory read port, one slot per cycle; other beats go straight from the check
// to the commit state. One beat is in work at a time, and the next is taken
// while a finished result waits in the output register.
module weekday_alarm_table #(
    parameter int ALARM_SLOTS = wat_pkg::ALARM_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  wat_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output wat_pkg::out_item_t out_data
);

    localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;

    wat_pkg::dp_cmd_t  cmd;
    wat_pkg::dp_stat_t stat;
    logic [IDX_W-1:0]  scan_idx;

    wat_ctrl #(
        .ALARM_SLOTS(ALARM_SLOTS),
        .IDX_W(IDX_W)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .stat(stat),
        .cmd(cmd),
        .scan_idx(scan_idx)
    );

    wat_dp #(
        .ALARM_SLOTS(ALARM_SLOTS),
        .IDX_W(IDX_W)
    ) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .scan_idx(scan_idx),
        .in_data(in_data),
        .out_ready(out_ready),
        .stat(stat),
        .out_valid(out_valid),
        .out_data(out_data)
    );

endmodule

// ===== rtl/wat_checker.sv =====
// Port-level checks for the weekday alarm table, bound to the top level.
// Depends on wat_pkg and weekday_alarm_table_defines.svh.
`include "weekday_alarm_table_defines.svh"

module wat_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input wat_pkg::out_item_t out_data
);

    `WAT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped while stalled")
    `WAT_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "stalled result beat changed")
    `WAT_ASSERT_IMP(a_ring_id, out_valid, out_data.ringing == (out_data.ringing_id != 32'd0), "ringing flag and id disagree")
    `WAT_ASSERT_IMP(a_fired, out_valid && out_data.fired_now, out_data.ringing && (out_data.status == wat_pkg::ST_OK), "fired beat not ringing")
    `WAT_ASSERT_NXT(a_one_at_time, in_valid && in_ready, !in_ready, "second beat taken during work")

endmodule

bind weekday_alarm_table wat_checker u_wat_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
);

// ===== verif/weekday_alarm_table_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for weekday_alarm_table: directed and random alarm commands with
// a cycle-free predictor of the alarm table. Depends on wat_pkg and the weekday_alarm_table RTL.
module weekday_alarm_table_tb;
    import wat_pkg::*;

    localparam int SLOTS = ALARM_SLOTS_DEF;
    localparam int RANDOM_CMDS = 850;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 60;
    localparam int ID_POOL = 20;
    localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] MODE_UNUSED_LAST = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;

    weekday_alarm_table dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    in_item_t cmd_queue[$];
    out_item_t predicted_replies[$];
    out_item_t oldest_reply;
    int fail_count = 0;
    int cmds_taken = 0;
    int phase_len = 1;
    int quiet_cycles = 0;
    int send_idle_pct;
    int recv_idle_pct;

    logic slot_used [SLOTS];
    slot_rec_t slot_rec [SLOTS];
    logic bell_on;
    logic [31:0] bell_id;

    logic [4:0] pool_hour [4];
    logic [5:0] pool_min [4];
    logic [15:0] gen_day;
    logic [2:0] gen_wd;

    assign send_idle_pct = (cmds_taken < phase_len) ? 24 : (cmds_taken < 2 * phase_len) ? 46 : 0;
    assign recv_idle_pct = (cmds_taken < phase_len) ? 46 : (cmds_taken < 2 * phase_len) ? 24 : 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic out_item_t run_alarm_cmd(input in_item_t c);
        out_item_t r;
        int pick;
        int n;
        logic day_ok;
        r = '0;
        r.status = ST_OK;
        pick = -1;
        case (c.mode)
            MODE_TICK:
            begin
                if (!bell_on && c.now_second == 6'd0)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        day_ok = (slot_rec[i].days == 7'd0) || (c.now_weekday != 3'd0 &&
                            |(slot_rec[i].days & (7'd1 << (c.now_weekday - 3'd1))));
                        if (slot_used[i] && slot_rec[i].active && day_ok
                            && !(slot_rec[i].fired_valid
                                 && slot_rec[i].fired_day == c.now_day_number)
                            && slot_rec[i].hour == c.now_hour
                            && slot_rec[i].minute == c.now_minute)
                        begin
                            if (pick < 0 || slot_rec[i].key < slot_rec[pick].key)
                                pick = i;
                        end
                    end
                    if (pick >= 0)
                    begin
                        bell_on = 1'b1;
                        bell_id = slot_rec[pick].key;
                        slot_rec[pick].fired_valid = 1'b1;
                        slot_rec[pick].fired_day = c.now_day_number;
                        r.fired_now = 1'b1;
                    end
                end
            end
            MODE_UPSERT:
            begin
                if (c.alarm_id == 32'd0)
                    r.status = ST_BAD_ID;
                else
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_used[i] && slot_rec[i].key == c.alarm_id)
                            pick = i;
                    if (pick < 0)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                            if (pick < 0 && !slot_used[i])
                                pick = i;
                    end
                    if (pick < 0)
                        r.status = ST_FULL;
                    else
                    begin
                        slot_used[pick] = 1'b1;
                        slot_rec[pick].key = c.alarm_id;
                        slot_rec[pick].hour = c.alarm_hour;
                        slot_rec[pick].minute = c.alarm_minute;
                        slot_rec[pick].days = c.day_mask;
                        slot_rec[pick].active = c.enable;
                        slot_rec[pick].fired_valid = 1'b0;
                        slot_rec[pick].fired_day = 16'd0;
                    end
                end
            end
            MODE_DELETE:
            begin
                if (c.alarm_id == 32'd0)
                    r.status = ST_BAD_ID;
                else
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_used[i] && slot_rec[i].key == c.alarm_id)
                            pick = i;
                    if (pick < 0)
                        r.status = ST_NOT_FOUND;
                    else
                        slot_used[pick] = 1'b0;
                end
            end
            MODE_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                    slot_used[i] = 1'b0;
            end
            MODE_DISMISS:
            begin
                if (!bell_on)
                    r.status = ST_IDLE;
                else
                begin
                    bell_on = 1'b0;
                    bell_id = 32'd0;
                end
            end
            default:
            begin
            end
        endcase
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i])
                n++;
        r.ringing = bell_on;
        r.ringing_id = bell_id;
        r.entry_count = n[4:0];
        return r;
    endfunction

    function automatic in_item_t blank_cmd(input logic [2:0] mode);
        logic [95:0] raw;
        in_item_t c;
        raw = {$urandom(), $urandom(), $urandom()};
        c = raw[$bits(in_item_t)-1:0];
        c.mode = mode;
        return c;
    endfunction

    function automatic in_item_t keyed_cmd(input logic [2:0] mode, input logic [31:0] id);
        in_item_t c;
        c = blank_cmd(mode);
        c.alarm_id = id;
        return c;
    endfunction

    function automatic in_item_t upsert_cmd(input logic [31:0] id, input logic [4:0] hour,
                                            input logic [5:0] minute, input logic [6:0] mask,
                                            input logic en);
        in_item_t c;
        c = keyed_cmd(MODE_UPSERT, id);
        c.alarm_hour = hour;
        c.alarm_minute = minute;
        c.day_mask = mask;
        c.enable = en;
        return c;
    endfunction

    function automatic in_item_t tick_cmd(input logic [4:0] hour, input logic [5:0] minute,
                                          input logic [5:0] second, input logic [2:0] wd,
                                          input logic [15:0] day);
        in_item_t c;
        c = blank_cmd(MODE_TICK);
        c.now_hour = hour;
        c.now_minute = minute;
        c.now_second = second;
        c.now_weekday = wd;
        c.now_day_number = day;
        return c;
    endfunction

    function automatic logic [31:0] pick_id();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return 32'd0;
        if (roll < 12)
            return $urandom();
        return $urandom_range(ID_POOL, 1);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_data <= cmd_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_replies.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result beat, expected none, got %0h",
                             $time, out_data);
                end
                else
                begin
                    oldest_reply = predicted_replies.pop_front();
                    check_field("status", 32'(oldest_reply.status), 32'(out_data.status));
                    check_field("fired_now", 32'(oldest_reply.fired_now),
                                32'(out_data.fired_now));
                    check_field("ringing", 32'(oldest_reply.ringing), 32'(out_data.ringing));
                    check_field("ringing_id", oldest_reply.ringing_id, out_data.ringing_id);
                    check_field("entry_count", 32'(oldest_reply.entry_count),
                                32'(out_data.entry_count));
                end
            end
            if (in_valid && in_ready)
            begin
                predicted_replies.push_back(run_alarm_cmd(in_data));
                cmds_taken++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int roll;
        int p;
        in_item_t c;
        for (int i = 0; i < SLOTS; i++)
            slot_used[i] = 1'b0;
        bell_on = 1'b0;
        bell_id = 32'd0;
        for (int i = 0; i < 4; i++)
        begin
            pool_hour[i] = 5'($urandom_range(23));
            pool_min[i] = 6'($urandom_range(59));
        end
        gen_day = 16'($urandom());
        gen_wd = 3'($urandom_range(7, 1));

        cmd_queue.push_back(blank_cmd(MODE_DISMISS));
        cmd_queue.push_back(upsert_cmd(32'd0, 5'd7, 6'd0, 7'd0, 1'b1));
        cmd_queue.push_back(keyed_cmd(MODE_DELETE, 32'd0));
        cmd_queue.push_back(keyed_cmd(MODE_DELETE, 32'd77));
        cmd_queue.push_back(upsert_cmd(32'hFFFF_FFFF, 5'd23, 6'd59, 7'd0, 1'b1));
        cmd_queue.push_back(upsert_cmd(32'd5, 5'd6, 6'd30, 7'b0000001, 1'b1));
        cmd_queue.push_back(upsert_cmd(32'd3, 5'd6, 6'd30, 7'd0, 1'b0));
        cmd_queue.push_back(tick_cmd(5'd6, 6'd30, 6'd0, 3'd1, 16'd100));
        cmd_queue.push_back(tick_cmd(5'd6, 6'd30, 6'd0, 3'd1, 16'd101));
        cmd_queue.push_back(keyed_cmd(MODE_DELETE, 32'd5));
        cmd_queue.push_back(blank_cmd(MODE_DISMISS));
        cmd_queue.push_back(upsert_cmd(32'd3, 5'd6, 6'd30, 7'd0, 1'b1));
        cmd_queue.push_back(tick_cmd(5'd6, 6'd30, 6'd5, 3'd1, 16'd100));
        cmd_queue.push_back(tick_cmd(5'd6, 6'd30, 6'd0, 3'd0, 16'd100));
        cmd_queue.push_back(blank_cmd(MODE_DISMISS));
        cmd_queue.push_back(tick_cmd(5'd6, 6'd30, 6'd0, 3'd0, 16'd100));
        cmd_queue.push_back(tick_cmd(5'd23, 6'd59, 6'd0, 3'd7, 16'hFFFF));
        cmd_queue.push_back(upsert_cmd(32'hFFFF_FFFF, 5'd0, 6'd0, 7'h7F, 1'b1));
        cmd_queue.push_back(blank_cmd(MODE_CLEAR));
        cmd_queue.push_back(blank_cmd(MODE_DISMISS));
        for (logic [2:0] m = MODE_UNUSED_FIRST; m != MODE_UNUSED_LAST; m++)
            cmd_queue.push_back(blank_cmd(m));
        cmd_queue.push_back(blank_cmd(MODE_UNUSED_LAST));
        cmd_queue.push_back(upsert_cmd(32'd9, 5'd31, 6'd63, 7'h40, 1'b1));
        cmd_queue.push_back(tick_cmd(5'd31, 6'd63, 6'd0, 3'd7, 16'd200));
        cmd_queue.push_back(blank_cmd(MODE_DISMISS));

        // Most ticks land on one of a few alarm times of the current day so that alarms fire.
        for (int k = 0; k < RANDOM_CMDS; k++)
        begin
            roll = $urandom_range(99);
            if (roll < 8)
            begin
                gen_day = gen_day + 16'd1;
                gen_wd = (gen_wd == 3'd7) ? 3'd1 : gen_wd + 3'd1;
            end
            else if (roll < 10)
                gen_day = 16'($urandom());
            p = $urandom_range(3);
            roll = $urandom_range(99);
            if (roll < 45)
            begin
                c = tick_cmd(pool_hour[p], pool_min[p], 6'd0, gen_wd, gen_day);
                if ($urandom_range(99) < 20)
                begin
                    c.now_hour = 5'($urandom());
                    c.now_minute = 6'($urandom());
                end
                if ($urandom_range(99) < 30)
                    c.now_second = 6'($urandom());
                if ($urandom_range(99) < 20)
                    c.now_weekday = 3'($urandom());
            end
            else if (roll < 72)
            begin
                c = upsert_cmd(pick_id(), pool_hour[p], pool_min[p], 7'd0,
                               $urandom_range(99) < 85);
                if ($urandom_range(99) < 20)
                begin
                    c.alarm_hour = 5'($urandom());
                    c.alarm_minute = 6'($urandom());
                end
                if ($urandom_range(99) < 70)
                    c.day_mask = 7'($urandom());
            end
            else if (roll < 80)
                c = keyed_cmd(MODE_DELETE, pick_id());
            else if (roll < 95)
                c = blank_cmd(MODE_DISMISS);
            else if (roll < 96)
                c = blank_cmd(MODE_CLEAR);
            else
                c = blank_cmd(3'($urandom_range(MODE_UNUSED_LAST, MODE_UNUSED_FIRST)));
            cmd_queue.push_back(c);
        end
        phase_len = cmd_queue.size() / 3;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (predicted_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
